// File: design/pse_pkg.sv
package pse_pkg;

	localparam int DATA_W          = 32;
	localparam int FUNC_W          = 3;
	localparam int STATUS_W        = 3;
	localparam int DEF_STACK_DEPTH = 16;

	// token kinds
	localparam logic [FUNC_W-1:0] FUNC_NUM = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_SUB = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_MUL = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DIV = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DIVZERO  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FEWOPS   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_READ_L,
		S_EXEC,
		S_MUL_WB,
		S_DIV,
		S_FINISH,
		S_READ_BOT
	} state_t;

	typedef enum logic [1:0] {
		RD_TOP,
		RD_NEXT,
		RD_BOTTOM
	} rd_sel_t;

	typedef enum logic [1:0] {
		WB_ADD,
		WB_SUB,
		WB_MUL,
		WB_DIV
	} wb_sel_t;

	typedef struct packed {
		logic                load;
		logic                push;
		logic                set_err;
		logic [STATUS_W-1:0] err_code;
		logic                rd_en;
		rd_sel_t             rd_sel;
		logic                grab_r;
		logic                mul_load;
		logic                div_start;
		logic                wb;
		wb_sel_t             wb_sel;
		logic                emit;
	} pse_cmd_t;

	typedef struct packed {
		logic              err_none;
		logic [FUNC_W-1:0] func;
		logic              last;
		logic              full;
		logic              few;
		logic              empty;
		logic              r_zero;
		logic              div_done;
		logic              out_busy;
	} pse_sts_t;

endpackage

// File: design/pse_tok_if.sv
interface pse_tok_if import pse_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic signed [DATA_W-1:0] operand;
	logic                     last;

	modport source (output valid, output func, output operand, output last, input ready);
	modport sink (input valid, input func, input operand, input last, output ready);
endinterface

// File: design/pse_res_if.sv
interface pse_res_if import pse_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value;
	logic [STATUS_W-1:0]      status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

// File: design/postfix_stack_evaluator.sv
// postfix (rpn) expression evaluator: tokens arrive one per transaction on
// the token channel, either a signed 32-bit number that is pushed on a
// STACK_DEPTH-entry value stack, or add, subtract, multiply or divide, which
// pop the right then the left operand and push left op right (results wrap
// to 32 bits, division truncates toward zero). the token marked last returns
// one transaction on the result channel with the bottom stack entry and a
// status (ok, divide by zero, too few operands, stack overflow, empty
// stack), then the stack and error are cleared. after the first error,
// tokens are ignored until the last one. one token is processed at a time;
// a divide runs through the 32 iterations of the radix-2 divider, and a
// last token on an error-free, non-empty stack adds a read of the bottom
// entry. a finished result waits in an output register, so the next token
// is taken while it is still held
module postfix_stack_evaluator import pse_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input logic        clk,
	input logic        arst_n,
	pse_tok_if.sink    token,
	pse_res_if.source  result
);

	pse_cmd_t cmd;
	pse_sts_t sts;

	// sequencer: decode, operand reads, writeback, result emission
	pse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (token.valid),
		.tok_ready (token.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// stack memory, counters, alu, divider and output register
	pse_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.tok_func    (token.func),
		.tok_operand (token.operand),
		.tok_last    (token.last),
		.res_valid   (result.valid),
		.res_ready   (result.ready),
		.res_value   (result.value),
		.res_status  (result.status)
	);

endmodule

// File: design/pse_div.sv
module pse_div import pse_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int STEPS = DATA_W;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   trial;

	always_comb begin
		shifted  = {rem_q, quo_q[DATA_W-1]};
		trial    = shifted - {1'b0, dvs_q};
		done     = busy_q && (cnt_q == '0);
		quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(STEPS);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	// magnitudes in, sign applied at the end
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
			dvs_q <= divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
			rem_q <= '0;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q <= trial[DATA_W] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], ~trial[DATA_W]};
		end
	end

endmodule

// File: design/pse_dp.sv
module pse_dp import pse_pkg::*; #(
	parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pse_cmd_t                 cmd,
	output pse_sts_t                 sts,
	input  logic [FUNC_W-1:0]        tok_func,
	input  logic signed [DATA_W-1:0] tok_operand,
	input  logic                     tok_last,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic signed [DATA_W-1:0] res_value,
	output logic [STATUS_W-1:0]      res_status
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [FUNC_W-1:0]   func_q;
	logic [DATA_W-1:0]   operand_q;
	logic                last_q;
	logic [CW-1:0]       count_q;
	logic [STATUS_W-1:0] err_q;
	logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
	logic [DATA_W-1:0]   rdata_q;
	logic [DATA_W-1:0]   r_q;
	logic [DATA_W-1:0]   res_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_value_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [CW-1:0]       cnt_m1;
	logic [CW-1:0]       cnt_m2;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [DATA_W-1:0]   wr_data;
	logic                wr_en;
	logic [2*DATA_W-1:0] prod;
	logic                div_done;
	logic [DATA_W-1:0]   div_q;

	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rdata_q),
		.divisor  (r_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		cnt_m1 = count_q - CW'(1);
		cnt_m2 = count_q - CW'(2);
		prod   = rdata_q * r_q;

		unique case (cmd.rd_sel)
			RD_TOP:    rd_addr = cnt_m1[AW-1:0];
			RD_NEXT:   rd_addr = cnt_m2[AW-1:0];
			RD_BOTTOM: rd_addr = '0;
			default:   rd_addr = '0;
		endcase

		wr_en   = cmd.push || cmd.wb;
		wr_addr = cmd.push ? count_q[AW-1:0] : cnt_m2[AW-1:0];
		unique case (cmd.wb_sel)
			WB_ADD:  wr_data = rdata_q + r_q;
			WB_SUB:  wr_data = rdata_q - r_q;
			WB_MUL:  wr_data = res_q;
			WB_DIV:  wr_data = div_q;
			default: wr_data = '0;
		endcase
		if (cmd.push) begin
			wr_data = operand_q;
		end

		sts.err_none = (err_q == ST_OK);
		sts.func     = func_q;
		sts.last     = last_q;
		sts.full     = (count_q == CW'(STACK_DEPTH));
		sts.few      = (count_q < CW'(2));
		sts.empty    = (count_q == '0);
		sts.r_zero   = (r_q == '0);
		sts.div_done = div_done;
		sts.out_busy = out_valid_q && !res_ready;

		res_valid  = out_valid_q;
		res_value  = out_value_q;
		res_status = out_status_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= stack_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= tok_func;
			operand_q <= tok_operand;
			last_q    <= tok_last;
		end
		if (cmd.grab_r) begin
			r_q <= rdata_q;
		end
		if (cmd.mul_load) begin
			res_q <= prod[DATA_W-1:0];
		end
		if (cmd.emit) begin
			if (err_q != ST_OK) begin
				out_value_q  <= '0;
				out_status_q <= err_q;
			end else if (count_q == '0) begin
				out_value_q  <= '0;
				out_status_q <= ST_EMPTY;
			end else begin
				out_value_q  <= rdata_q;
				out_status_q <= ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				count_q <= '0;
				err_q   <= ST_OK;
			end else begin
				if (cmd.push) begin
					count_q <= count_q + CW'(1);
				end else if (cmd.wb) begin
					count_q <= cnt_m1;
				end
				if (cmd.set_err) begin
					err_q <= cmd.err_code;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: design/pse_ctrl.sv
module pse_ctrl import pse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     tok_valid,
	output logic     tok_ready,
	input  pse_sts_t sts,
	output pse_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		tok_ready = 1'b0;
		cmd       = '{
			load: 1'b0, push: 1'b0, set_err: 1'b0, err_code: ST_OK,
			rd_en: 1'b0, rd_sel: RD_TOP, grab_r: 1'b0, mul_load: 1'b0,
			div_start: 1'b0, wb: 1'b0, wb_sel: WB_ADD, emit: 1'b0
		};

		unique case (state_q)
			S_IDLE: begin
				tok_ready = 1'b1;
				if (tok_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_FINISH;
				if (!sts.err_none) begin
					state_d = S_FINISH;
				end else if (sts.func == FUNC_NUM) begin
					if (sts.full) begin
						cmd.set_err  = 1'b1;
						cmd.err_code = ST_OVERFLOW;
					end else begin
						cmd.push = 1'b1;
					end
				end else if (sts.func > FUNC_DIV) begin
					state_d = S_FINISH;
				end else if (sts.few) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_FEWOPS;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_TOP;
					state_d    = S_READ_L;
				end
			end
			S_READ_L: begin
				cmd.grab_r = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_NEXT;
				state_d    = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_FINISH;
				if (sts.func == FUNC_ADD) begin
					cmd.wb     = 1'b1;
					cmd.wb_sel = WB_ADD;
				end else if (sts.func == FUNC_SUB) begin
					cmd.wb     = 1'b1;
					cmd.wb_sel = WB_SUB;
				end else if (sts.func == FUNC_MUL) begin
					cmd.mul_load = 1'b1;
					state_d      = S_MUL_WB;
				end else if (sts.r_zero) begin
					cmd.set_err  = 1'b1;
					cmd.err_code = ST_DIVZERO;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_MUL_WB: begin
				cmd.wb     = 1'b1;
				cmd.wb_sel = WB_MUL;
				state_d    = S_FINISH;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.wb     = 1'b1;
					cmd.wb_sel = WB_DIV;
					state_d    = S_FINISH;
				end
			end
			S_FINISH: begin
				if (!sts.last) begin
					state_d = S_IDLE;
				end else if (!sts.out_busy) begin
					if (!sts.err_none || sts.empty) begin
						cmd.emit = 1'b1;
						state_d  = S_IDLE;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = RD_BOTTOM;
						state_d    = S_READ_BOT;
					end
				end
			end
			S_READ_BOT: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
